>>> src/csvs_pkg.sv
// Shared types and constants for the CSV field splitter.
// Used by csvs_ctrl, csvs_datapath and the top level; depends on nothing.
package csvs_pkg;

    // Whitespace hold buffer
    localparam int PENDING_DEPTH = 16;
    localparam int STORE_DEPTH   = 16;
    localparam int HOLD_CAP      = (PENDING_DEPTH > STORE_DEPTH) ? STORE_DEPTH : PENDING_DEPTH;
    localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Results per item are bounded; held bytes beyond this are trimmed on a line end
    localparam int MAX_RESULTS   = 17;
    localparam int TRIM_LIMIT    = MAX_RESULTS - 2;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] COMMA_CHAR = 8'h2C;

    // Result source selected for the output register
    typedef enum logic [1:0] {
        SEL_PEND,
        SEL_CONTENT,
        SEL_FE_COMMA,
        SEL_FE_LINE
    } t_sel;

    // Results still owed for one item, in emission order
    typedef struct packed {
        logic flush;
        logic content;
        logic fe_comma;
        logic fe_line;
    } t_plan;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        t_sel sel;
        logic last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_plan dec;
        t_plan rem;
        logic  flush_last;
        logic  out_free;
    } t_status;

endpackage

>>> src/csvs_ctrl.sv
// Sequencer for the CSV field splitter: walks the results of one item.
// Depends on csvs_pkg.
module csvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  csvs_pkg::t_status i_status,
    output logic              o_stall,
    output csvs_pkg::t_cmd    o_cmd
);
    import csvs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_CONTENT,
        ST_FE_COMMA,
        ST_FE_LINE
    } t_state;

    t_state r_state, n_state;
    t_plan  rem_after;

    // First result source still owed, or idle when none
    function automatic t_state first_state(input t_plan p);
        t_state s;
        if (p.flush) begin
            s = ST_FLUSH;
        end else if (p.content) begin
            s = ST_CONTENT;
        end else if (p.fe_comma) begin
            s = ST_FE_COMMA;
        end else if (p.fe_line) begin
            s = ST_FE_LINE;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.sel    = SEL_PEND;
        o_cmd.last   = 1'b0;
        rem_after    = i_status.rem;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = first_state(i_status.dec);
                end
            end
            ST_FLUSH: begin
                o_cmd.sel       = SEL_PEND;
                rem_after.flush = !i_status.flush_last;
            end
            ST_CONTENT: begin
                o_cmd.sel         = SEL_CONTENT;
                rem_after.content = 1'b0;
            end
            ST_FE_COMMA: begin
                o_cmd.sel          = SEL_FE_COMMA;
                rem_after.fe_comma = 1'b0;
            end
            ST_FE_LINE: begin
                o_cmd.sel         = SEL_FE_LINE;
                rem_after.fe_line = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // one result per cycle whenever the output register has room
        if (r_state != ST_IDLE && i_status.out_free) begin
            o_cmd.load = 1'b1;
            o_cmd.last = (rem_after == '0);
            n_state    = first_state(rem_after);
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result is loaded only while a sequence runs
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state != ST_IDLE))
        else $error("result load outside a sequence");

    // The last result of a sequence returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("sequence did not end after its last result");

    // An accepted item never coincides with a result load
    a_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.load))
        else $error("accept and load in the same cycle");

endmodule

>>> src/csvs_datapath.sv
// Datapath for the CSV field splitter: parse state, whitespace hold buffer,
// result plan and the output register. Depends on csvs_pkg.
module csvs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_has_byte,
    input  logic              i_line_end,
    input  csvs_pkg::t_cmd    i_cmd,
    input  logic              i_out_stall,
    output csvs_pkg::t_status o_status,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_field_end,
    output logic              o_is_record_end,
    output logic              o_ws_overflow,
    output logic              o_last_of_run
);
    import csvs_pkg::*;

    // Parse state
    logic             r_inq, n_inq;
    logic             r_qseen, n_qseen;
    logic             r_started, n_started;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [7:0]       r_buf [STORE_DEPTH];

    // Plan of the item in progress
    t_plan            r_plan, n_plan;
    logic [CNT_W-1:0] r_flush_n, n_flush_n;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [7:0]       r_cbyte;

    // Output register
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_ofe, r_ore, r_oovf, r_olast;

    // Item decode
    logic             take, plain, is_ws, ws_write;
    logic [7:0]       tc;
    t_plan            dec;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Decode the item at the input against the parse state
    always_comb begin
        n_inq     = r_inq;
        n_qseen   = r_qseen;
        n_started = r_started;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_flush_n = '0;
        dec       = '0;
        take      = 1'b0;
        plain     = 1'b0;
        tc        = i_in_byte;
        ws_write  = 1'b0;
        if (i_has_byte) begin
            if (r_inq) begin
                if (r_qseen) begin
                    n_qseen = 1'b0;
                    if (i_in_byte == QUOTE_CHAR) begin
                        take = 1'b1;
                    end else begin
                        n_inq = 1'b0;
                        plain = 1'b1;
                    end
                end else if (i_in_byte == QUOTE_CHAR) begin
                    n_qseen = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end else begin
                plain = 1'b1;
            end
            if (plain) begin
                if (i_in_byte == QUOTE_CHAR) begin
                    n_inq = 1'b1;
                end else if (i_in_byte == COMMA_CHAR) begin
                    dec.fe_comma = 1'b1;
                    n_cnt        = '0;
                    n_started    = 1'b0;
                end else begin
                    take = 1'b1;
                end
            end
        end
        is_ws = is_space(tc);
        if (take && is_ws) begin
            // inner whitespace is held, leading whitespace vanishes
            if (r_started) begin
                if (r_cnt < CNT_W'(HOLD_CAP)) begin
                    ws_write = 1'b1;
                    n_cnt    = r_cnt + CNT_W'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
        end else if (take) begin
            // content byte releases the held whitespace first
            n_flush_n = r_cnt;
            if (i_line_end && r_cnt > CNT_W'(TRIM_LIMIT)) begin
                n_flush_n = CNT_W'(TRIM_LIMIT);
                n_drop    = 1'b1;
            end
            dec.flush   = (n_flush_n != '0);
            dec.content = 1'b1;
            n_started   = 1'b1;
            n_cnt       = '0;
        end
        if (i_line_end) begin
            n_inq       = 1'b0;
            n_qseen     = 1'b0;
            n_cnt       = '0;
            n_started   = 1'b0;
            dec.fe_line = 1'b1;
        end
    end

    // Plan update as results leave
    always_comb begin
        n_plan = r_plan;
        if (i_cmd.accept) begin
            n_plan = dec;
        end else if (i_cmd.load) begin
            case (i_cmd.sel)
                SEL_PEND:     n_plan.flush    = !o_status.flush_last;
                SEL_CONTENT:  n_plan.content  = 1'b0;
                SEL_FE_COMMA: n_plan.fe_comma = 1'b0;
                SEL_FE_LINE:  n_plan.fe_line  = 1'b0;
                default:      n_plan          = r_plan;
            endcase
        end
    end

    assign o_status.dec        = dec;
    assign o_status.rem        = r_plan;
    assign o_status.flush_last = ((r_rd_cnt + CNT_W'(1)) == r_flush_n);
    assign o_status.out_free   = !r_ovalid || !i_out_stall;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq     <= 1'b0;
            r_qseen   <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_plan    <= '0;
            r_ovalid  <= 1'b0;
            r_rd_cnt  <= '0;
        end else begin
            r_plan <= n_plan;
            if (i_cmd.accept) begin
                r_inq     <= n_inq;
                r_qseen   <= n_qseen;
                r_started <= n_started;
                r_cnt     <= n_cnt;
                r_drop    <= n_drop;
                r_rd_cnt  <= '0;
            end else if (i_cmd.load) begin
                // overflow mark rides on the next result only
                r_drop <= 1'b0;
                if (i_cmd.sel == SEL_PEND) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_flush_n <= n_flush_n;
            r_cbyte   <= tc;
            if (ws_write) begin
                r_buf[r_cnt[IDX_W-1:0]] <= tc;
            end
        end
        if (i_cmd.load) begin
            r_oovf  <= r_drop;
            r_olast <= i_cmd.last;
            case (i_cmd.sel)
                SEL_PEND: begin
                    r_obyte <= r_buf[r_rd_cnt[IDX_W-1:0]];
                    r_ofe   <= 1'b0;
                    r_ore   <= 1'b0;
                end
                SEL_CONTENT: begin
                    r_obyte <= r_cbyte;
                    r_ofe   <= 1'b0;
                    r_ore   <= 1'b0;
                end
                SEL_FE_COMMA: begin
                    r_obyte <= 8'h00;
                    r_ofe   <= 1'b1;
                    r_ore   <= 1'b0;
                end
                default: begin
                    r_obyte <= 8'h00;
                    r_ofe   <= 1'b1;
                    r_ore   <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_byte      = r_obyte;
    assign o_is_field_end  = r_ofe;
    assign o_is_record_end = r_ore;
    assign o_ws_overflow   = r_oovf;
    assign o_last_of_run   = r_olast;

    // Hold count never passes the buffer capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HOLD_CAP))
        else $error("whitespace hold count above capacity");

    // A result is never loaded over one that is still stalled
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_ovalid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // Held bytes are read only within the planned flush length
    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.sel == SEL_PEND) |-> (r_plan.flush && r_rd_cnt < r_flush_n))
        else $error("held byte read beyond flush length");

    // A new item finds no results still owed
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (r_plan == '0))
        else $error("item accepted with results outstanding");

endmodule

>>> src/csv_field_splitter_trimmed_core.sv
// Top level of the CSV field splitter with whitespace trimming.
// Instantiates csvs_ctrl and csvs_datapath; depends on csvs_pkg.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_in_byte, i_has_byte, i_line_end
//  output   out        o_valid / i_stall   o_out_byte, o_is_field_end,
//                                          o_is_record_end, o_ws_overflow,
//                                          o_last_of_run
//
// An item is taken in its accept cycle; its results then go one per cycle into the
// output register while that register has room, and an item with no results leaves
// the sequencer idle. Up to 17 results per item.
// o_stall is high from the cycle after an accept until the last result is loaded.
// Output stalls hold the sequence in place; the next item is taken while the
// last result still waits. Synchronous active-low reset; no clearing pass.
module csv_field_splitter_trimmed_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_has_byte,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_field_end,
    output logic       o_is_record_end,
    output logic       o_ws_overflow,
    output logic       o_last_of_run
);
    import csvs_pkg::*;

    t_cmd    cmd;
    t_status status;

    csvs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    csvs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_has_byte      (i_has_byte),
        .i_line_end      (i_line_end),
        .i_cmd           (cmd),
        .i_out_stall     (i_stall),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_is_field_end  (o_is_field_end),
        .o_is_record_end (o_is_record_end),
        .o_ws_overflow   (o_ws_overflow),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

>>> verif/csvs_field_check.sv
// Field checker for the CSV field splitter: predicts the results of every item that
// the block takes and compares them, in order, with the results it hands out.
// Depends on csvs_pkg for the buffer sizes and the quote and comma characters.
module csvs_field_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_has_byte,
    input  logic       i_line_end,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_field_end,
    input  logic       i_record_end,
    input  logic       i_ws_overflow,
    input  logic       i_last_of_run,
    output int         o_errors,
    output int         o_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import csvs_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       field_end;
        logic       record_end;
        logic       overflow;
        logic       last;
    } t_field_res;

    // Results predicted but not yet seen, oldest first
    t_field_res owed_results[$];
    t_field_res got;
    t_field_res want;

    // Shadow of the splitter state
    logic       in_quote;
    logic       quote_wait;
    logic       started;
    logic       dropped;
    logic [7:0] held_ws [STORE_DEPTH];
    int         held_n;
    int         made;

    function automatic logic is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Queue one result; it carries and clears the dropped-whitespace flag
    function automatic void push_result(logic [7:0] b, logic fe, logic re);
        t_field_res r;
        if (made < MAX_RESULTS) begin
            r = '{data: b, field_end: fe, record_end: re, overflow: dropped, last: 1'b0};
            owed_results.insert(owed_results.size(), r);
            dropped = 1'b0;
            made++;
        end
    endfunction

    // Whitespace is held or dropped; content flushes the held bytes first
    function automatic void take_char(logic [7:0] c, logic le);
        if (is_blank(c)) begin
            if (!started)
                return;
            if (held_n < HOLD_CAP) begin
                held_ws[held_n] = c;
                held_n++;
            end else begin
                dropped = 1'b1;
            end
            return;
        end
        // a line end caps the flush so the item stays within its result budget
        if (le && held_n > TRIM_LIMIT) begin
            held_n  = TRIM_LIMIT;
            dropped = 1'b1;
        end
        for (int i = 0; i < held_n && i < STORE_DEPTH; i++)
            push_result(held_ws[i], 1'b0, 1'b0);
        held_n = 0;
        push_result(c, 1'b0, 1'b0);
        started = 1'b1;
    endfunction

    function automatic void end_field(logic rec);
        held_n  = 0;
        started = 1'b0;
        push_result(8'h00, 1'b1, rec);
    endfunction

    function automatic void split_byte(logic [7:0] c, logic has, logic le);
        logic plain;
        plain = 1'b0;
        made  = 0;
        if (has) begin
            if (in_quote) begin
                if (quote_wait) begin
                    quote_wait = 1'b0;
                    if (c == QUOTE_CHAR) begin
                        take_char(QUOTE_CHAR, le);
                    end else begin
                        in_quote = 1'b0;
                        plain    = 1'b1;
                    end
                end else if (c == QUOTE_CHAR) begin
                    quote_wait = 1'b1;
                end else begin
                    take_char(c, le);
                end
            end else begin
                plain = 1'b1;
            end
            if (plain) begin
                if (c == QUOTE_CHAR)
                    in_quote = 1'b1;
                else if (c == COMMA_CHAR)
                    end_field(1'b0);
                else
                    take_char(c, le);
            end
        end
        // a line end closes any open span along with the record
        if (le) begin
            in_quote   = 1'b0;
            quote_wait = 1'b0;
            end_field(1'b1);
        end
        if (made > 0)
            owed_results[owed_results.size() - 1].last = 1'b1;
    endfunction

    // Results are checked before the item of the same edge is predicted,
    // so a result can never match an expectation made at that edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_quote   = 1'b0;
            quote_wait = 1'b0;
            started    = 1'b0;
            dropped    = 1'b0;
            held_n     = 0;
            o_errors   = 0;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{data: i_out_byte, field_end: i_field_end, record_end: i_record_end,
                        overflow: i_ws_overflow, last: i_last_of_run};
                if (owed_results.size() == 0) begin
                    $error("unexpected result: out_byte %0h field_end %0b record_end %0b",
                           got.data, got.field_end, got.record_end);
                    o_errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, actual %0h", want.data, got.data);
                        o_errors++;
                    end
                    if (got.field_end !== want.field_end) begin
                        $error("is_field_end: expected %0b, actual %0b",
                               want.field_end, got.field_end);
                        o_errors++;
                    end
                    if (got.record_end !== want.record_end) begin
                        $error("is_record_end: expected %0b, actual %0b",
                               want.record_end, got.record_end);
                        o_errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("ws_overflow: expected %0b, actual %0b",
                               want.overflow, got.overflow);
                        o_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, got.last);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                split_byte(i_in_byte, i_has_byte, i_line_end);
        end
        o_owed = owed_results.size();
    end

endmodule

>>> verif/csv_field_splitter_trimmed_core_tb.sv
// Testbench top for csv_field_splitter_trimmed_core: drives CSV lines, stalls the
// result side and gives the verdict. Depends on csvs_pkg and csvs_field_check.
module csv_field_splitter_trimmed_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csvs_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_has_byte = 1'b0;
    logic       i_line_end = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_is_field_end;
    logic       o_is_record_end;
    logic       o_ws_overflow;
    logic       o_last_of_run;

    int   errors;
    int   owed;
    int   sent = 0;
    int   quiet = 0;
    logic calm = 1'b0;

    csv_field_splitter_trimmed_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_has_byte     (i_has_byte),
        .i_line_end     (i_line_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_is_field_end (o_is_field_end),
        .o_is_record_end(o_is_record_end),
        .o_ws_overflow  (o_ws_overflow),
        .o_last_of_run  (o_last_of_run)
    );

    csvs_field_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_has_byte   (i_has_byte),
        .i_line_end   (i_line_end),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_field_end  (o_is_field_end),
        .i_record_end (o_is_record_end),
        .i_ws_overflow(o_ws_overflow),
        .i_last_of_run(o_last_of_run),
        .o_errors     (errors),
        .o_owed       (owed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: ends the run after a long stretch with no item moving either way
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("csv_field_splitter_trimmed_core_tb: errors");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // Result side: random stall before each result, none in calm stretches
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            n = calm ? 0 : $urandom_range(0, 5);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // One item: optional gap, then hold it until the block takes it
    task automatic send_item(logic [7:0] b, logic has, logic le);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_byte  <= b;
        i_has_byte <= has;
        i_line_end <= le;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (has || le)
            sent++;
    endtask

    // Sender holds off until every predicted result has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (owed != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // Any byte but a quote, a comma or whitespace
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == QUOTE_CHAR || c == COMMA_CHAR || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
        return c;
    endfunction

    task automatic send_blanks(int n);
        repeat (n) send_item(blank_char(), 1'b1, 1'b0);
    endtask

    // One line of fields: plain, quoted, long inner whitespace, or empty
    task automatic send_record();
        int   nf;
        logic last_field;
        logic closed;
        nf     = $urandom_range(1, 4);
        closed = 1'b0;
        for (int f = 0; f < nf; f++) begin
            last_field = (f == nf - 1);
            send_blanks($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(0, 6))
                        send_item(($urandom_range(0, 3) == 0) ? blank_char() : text_char(),
                                  1'b1, 1'b0);
                end
                1: begin
                    send_item(QUOTE_CHAR, 1'b1, 1'b0);
                    repeat ($urandom_range(0, 8)) begin
                        case ($urandom_range(0, 9))
                            0, 1: send_item(COMMA_CHAR, 1'b1, 1'b0);
                            2: begin
                                send_item(QUOTE_CHAR, 1'b1, 1'b0);
                                send_item(QUOTE_CHAR, 1'b1, 1'b0);
                            end
                            3, 4: send_item(blank_char(), 1'b1, 1'b0);
                            default: send_item(text_char(), 1'b1, 1'b0);
                        endcase
                    end
                    // a span left open runs on into the following fields
                    if ($urandom_range(0, 3) != 0)
                        send_item(QUOTE_CHAR, 1'b1, 1'b0);
                    if ($urandom_range(0, 3) == 0)
                        send_item(text_char(), 1'b1, 1'b0);
                end
                2: begin
                    // enough inner whitespace that it can overrun the hold buffer
                    send_item(text_char(), 1'b1, 1'b0);
                    send_blanks($urandom_range(10, 20));
                    closed = last_field && ($urandom_range(0, 1) == 1);
                    send_item(text_char(), 1'b1, closed);
                end
                default: ;
            endcase
            if (!closed) begin
                send_blanks($urandom_range(0, 3));
                if (!last_field)
                    send_item(COMMA_CHAR, 1'b1, 1'b0);
            end
        end
        if (!closed) begin
            if ($urandom_range(0, 1) == 1)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            else
                send_item(($urandom_range(0, 1) == 1) ? blank_char() : text_char(), 1'b1, 1'b1);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty record, empty item, byte extremes
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(COMMA_CHAR, 1'b1, 1'b0);
        // leading whitespace dropped, inner held and flushed, trailing trimmed
        send_item(8'h20, 1'b1, 1'b0);
        send_item(8'h09, 1'b1, 1'b0);
        send_item("x", 1'b1, 1'b0);
        send_item(8'h0D, 1'b1, 1'b0);
        send_item(8'h0A, 1'b1, 1'b0);
        send_item("y", 1'b1, 1'b0);
        send_item(8'h0B, 1'b1, 1'b0);
        send_item(8'h0C, 1'b1, 1'b0);
        send_item(COMMA_CHAR, 1'b1, 1'b0);
        // quoted comma, doubled quote, quote followed by plain byte
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item(COMMA_CHAR, 1'b1, 1'b0);
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item("z", 1'b1, 1'b0);
        // quote still undecided when the line ends
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // line end inside an open span
        send_item(QUOTE_CHAR, 1'b1, 1'b0);
        send_item("q", 1'b1, 1'b1);
        // full hold buffer, then content on the line end trims the flush
        send_item("a", 1'b1, 1'b0);
        send_blanks(20);
        send_item("b", 1'b1, 1'b1);
        wait_drained();

        // Mostly well-formed lines, some raw noise
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) == 0));
            end else begin
                send_record();
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("csv_field_splitter_trimmed_core_tb: clean");
        else
            $display("csv_field_splitter_trimmed_core_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
src/csvs_pkg.sv
src/csvs_ctrl.sv
src/csvs_datapath.sv
src/csv_field_splitter_trimmed_core.sv
verif/csvs_field_check.sv
verif/csv_field_splitter_trimmed_core_tb.sv
